[hw/rtl/critically_damped_angle_follower_macros.svh]
// Assertion macros shared by the angle follower RTL.
`ifndef CRITICALLY_DAMPED_ANGLE_FOLLOWER_MACROS_SVH
`define CRITICALLY_DAMPED_ANGLE_FOLLOWER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CDAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cdaf assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CDAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cdaf assertion failed");

`endif

[hw/rtl/cdaf_pkg.sv]
// Constants, types and helper functions of the angle follower.
`default_nettype none
package cdaf_pkg;

	localparam int PI_Q12     = 12868;
	localparam int TWO_PI_Q12 = 25736;
	localparam int ST_MIN     = 7;
	localparam int C048       = 31457;
	localparam int C0235      = 15401;
	localparam int X_CAP      = 128 << 16;
	localparam int VEL_MAX    = 8388607;
	localparam int VEL_MIN    = -8388608;

	localparam int DIV_NW    = 44;
	localparam int DIV_DW    = 37;
	localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

	localparam int MUL_AW = 42;
	localparam int MUL_BW = 25;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// floor(2^24 / 2*pi): the quotient estimate is low by at most one
	localparam int WRAP_RECIP = 651;
	localparam int WRAP_SHIFT = 24;
	localparam int WRAP_QW    = 10;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_WRD_GO,
		S_WRD_Q,
		S_WRD_M,
		S_WRD_FOLD,
		S_X_GO,
		S_X_WAIT,
		S_M_XX,
		S_T_X2,
		S_M_X2X,
		S_T_X3,
		S_M_C048,
		S_T_C048,
		S_M_C0235,
		S_T_DEN,
		S_DEC_GO,
		S_DEC_WAIT,
		S_OC_GO,
		S_OC_WAIT,
		S_M_TMP,
		S_T_TMP,
		S_OT_GO,
		S_OT_WAIT,
		S_M_NV,
		S_T_NV,
		S_M_RES,
		S_T_RES,
		S_WRR_GO,
		S_WRR_Q,
		S_WRR_M,
		S_WRR_FOLD,
		S_OUT
	} state_t;

	// Shift right by 16, rounding halves away from zero.
	function automatic logic signed [MUL_PW-1:0] rnd16(input logic signed [MUL_PW-1:0] v);
		logic [MUL_PW-1:0] mag;
		logic [MUL_PW-1:0] r;
		mag = v[MUL_PW-1] ? MUL_PW'(-v) : MUL_PW'(v);
		r = (mag + MUL_PW'(1 << 15)) >> 16;
		return v[MUL_PW-1] ? -signed'(r) : signed'(r);
	endfunction

	// Turn a remainder by 2*pi of a magnitude into an angle in (-pi, pi].
	function automatic logic signed [15:0] wrap_fix(input logic neg, input logic [14:0] r);
		logic [15:0] m;
		if (neg) begin
			m = (r == 15'd0) ? 16'd0 : 16'(TWO_PI_Q12) - {1'b0, r};
		end else begin
			m = {1'b0, r};
		end
		return (m == 16'd0) ? 16'(PI_Q12) : signed'(m - 16'(PI_Q12));
	endfunction

endpackage
`default_nettype wire

[hw/rtl/cdaf_ifs.sv]
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface cdaf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] current_angle;
	logic signed [15:0] target_angle;
	logic        [15:0] time_step;
	logic               clear_velocity;

	modport source (output valid, output current_angle, output target_angle,
		output time_step, output clear_velocity, input ready);
	modport sink (input valid, input current_angle, input target_angle,
		input time_step, input clear_velocity, output ready);
endinterface

interface cdaf_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] new_angle;
	logic               snapped;

	modport source (output valid, output new_angle, output snapped, input ready);
	modport sink (input valid, input new_angle, input snapped, output ready);
endinterface
`default_nettype wire

[hw/rtl/cdaf_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module cdaf_div
	import cdaf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output div_status_t            status,
	output logic      [DIV_NW-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    num_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    den_q;
	logic [DIV_DW:0]      trial;
	logic                 ge;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in the next numerator bit, subtract when it fits
			rem_q <= ge ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quot        = num_q;

endmodule
`default_nettype wire

[hw/rtl/critically_damped_angle_follower.sv]
// Critically damped angle follower: top level with sequencer and shared multiplier.
//
// Usage: write smooth_time (index 0) and wrap_result (index 1) through the
// cfg_we/cfg_index/cfg_wdata port while idle. Send one word per update on
// the sample channel (current angle, target angle, time step, clear flag);
// one result word (new angle, snapped flag) comes back on the result channel.
// A sample word is taken only while the sequencer is idle, so a new word
// waits until the last result is loaded into the output register. The
// run is set by the 44-step restoring divider, used four times, plus the
// shared 42x25 multiplier and rounding steps; each wrap by 2*pi, of the
// angle difference and, with result wrapping on, of the result, estimates
// the multiple on the multiplier, multiplies it back and folds once.
// Reset sets smooth_time to 3745, turns wrapping off and zeroes the stored
// velocity; the block is ready as soon as reset is released.
// The result sits in an output register until taken. A stalled receiver
// holds the finished result there and keeps the next word waiting in the
// final step of the sequencer until the register frees.
`default_nettype none
`include "critically_damped_angle_follower_macros.svh"
module critically_damped_angle_follower
	import cdaf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	cdaf_in_if.sink          sample,
	cdaf_out_if.source       result,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam logic CFG_SMOOTH_TIME = 1'b0;
	localparam logic CFG_WRAP_RESULT = 1'b1;

	state_t state_q, state_d;

	logic [15:0] smooth_time_q;
	logic        wrap_result_q;

	logic signed [15:0] cur_q, tgt_q;
	logic        [15:0] dt_q;
	logic signed [23:0] vel_q;
	logic               neg_q;
	logic signed [15:0] diff_q;
	logic signed [17:0] to_q;
	logic signed [16:0] change_q;
	logic        [23:0] x_q;
	logic        [30:0] x2_q;
	logic        [37:0] x3_q;
	logic [DIV_DW-1:0]  den_q;
	logic        [16:0] dec_q;
	logic signed [18:0] oc_q;
	logic signed [24:0] temp_q;
	logic signed [39:0] ot_q;
	logic signed [40:0] nv_q;
	logic signed [26:0] res_q;
	logic               snap_q;
	logic        [27:0] wmag_q;
	logic [WRAP_QW-1:0] wq_q;
	logic signed [MUL_PW-1:0] prod_q;

	logic               out_valid_q;
	logic signed [15:0] out_angle_q;
	logic               out_snap_q;

	logic                     div_start;
	logic [DIV_NW-1:0]        div_num;
	logic [DIV_DW-1:0]        div_den;
	div_status_t              div_st;
	logic [DIV_NW-1:0]        div_quot;

	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] prod;
	logic signed [MUL_PW-1:0] prod_r;

	logic        [15:0] st_w;
	logic        [15:0] half_st;
	logic        [19:0] st10;
	logic        [15:0] maxc;
	logic signed [17:0] u_diff;
	logic        [16:0] u_diff_mag;
	logic signed [27:0] u_res;
	logic        [27:0] u_res_mag;
	logic signed [17:0] chg_raw;
	logic signed [17:0] maxc_s;
	logic        [16:0] change_mag;
	logic        [23:0] temp_mag;
	logic signed [26:0] res_w;
	logic               snap_w;
	logic               accept;
	logic               load_out;
	logic signed [15:0] res_sat;
	logic signed [39:0] q_ot;
	logic signed [18:0] q_oc;
	logic        [27:0] wrap_diff;
	logic        [14:0] wrap_rem;

	assign st_w    = (smooth_time_q < 16'(ST_MIN)) ? 16'(ST_MIN) : smooth_time_q;
	assign half_st = st_w >> 1;
	assign st10    = 20'(st_w) * 20'd10;
	assign maxc    = 16'((st10 + 20'd8) >> 4);
	assign maxc_s  = signed'({2'b00, maxc});

	assign u_diff     = 18'(tgt_q) - 18'(cur_q) + 18'(PI_Q12);
	assign u_diff_mag = u_diff[17] ? 17'(-u_diff) : 17'(u_diff);
	assign u_res      = 28'(res_q) + 28'(PI_Q12);
	assign u_res_mag  = u_res[27] ? 28'(-u_res) : 28'(u_res);
	assign chg_raw    = 18'(cur_q) - to_q;
	assign change_mag = change_q[16] ? 17'(-change_q) : 17'(change_q);
	assign temp_mag   = temp_q[24] ? 24'(-temp_q) : 24'(temp_q);

	assign prod   = mul_a * mul_b;
	assign prod_r = rnd16(prod_q);

	// magnitude less the estimated multiple of 2*pi, below 4*pi; fold once
	assign wrap_diff = wmag_q - prod_q[27:0];
	assign wrap_rem  = (wrap_diff >= 28'(TWO_PI_Q12)) ?
		15'(wrap_diff - 28'(TWO_PI_Q12)) : wrap_diff[14:0];

	assign res_w  = 27'(to_q) + prod_r[26:0];
	assign snap_w = (diff_q > 16'sd0) == (res_w > 27'(to_q));

	assign q_ot = signed'({1'b0, div_quot[38:0]});
	assign q_oc = signed'({1'b0, div_quot[17:0]});

	assign res_sat = (res_q > 27'sd32767) ? 16'sh7fff :
		(res_q < -27'sd32768) ? 16'sh8000 : res_q[15:0];

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign load_out     = (state_q == S_OUT) && (!out_valid_q || result.ready);

	cdaf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.status (div_st),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_IDLE: begin
				if (sample.valid) state_d = S_WRD_GO;
			end
			S_WRD_GO: begin
				mul_a   = MUL_AW'(WRAP_RECIP);
				mul_b   = MUL_BW'(u_diff_mag);
				state_d = S_WRD_Q;
			end
			S_WRD_Q:   state_d = S_WRD_M;
			S_WRD_M: begin
				mul_a   = MUL_AW'(wq_q);
				mul_b   = MUL_BW'(TWO_PI_Q12);
				state_d = S_WRD_FOLD;
			end
			S_WRD_FOLD: state_d = S_X_GO;
			S_X_GO: begin
				div_start = 1'b1;
				div_num   = (DIV_NW'(dt_q) << 17) + DIV_NW'(half_st);
				div_den   = DIV_DW'(st_w);
				state_d   = S_X_WAIT;
			end
			S_X_WAIT: begin
				if (div_st.done) state_d = S_M_XX;
			end
			S_M_XX: begin
				mul_a   = MUL_AW'(x_q);
				mul_b   = MUL_BW'(x_q);
				state_d = S_T_X2;
			end
			S_T_X2:    state_d = S_M_X2X;
			S_M_X2X: begin
				mul_a   = MUL_AW'(x2_q);
				mul_b   = MUL_BW'(x_q);
				state_d = S_T_X3;
			end
			S_T_X3:    state_d = S_M_C048;
			S_M_C048: begin
				mul_a   = MUL_AW'(x2_q);
				mul_b   = MUL_BW'(C048);
				state_d = S_T_C048;
			end
			S_T_C048:  state_d = S_M_C0235;
			S_M_C0235: begin
				mul_a   = MUL_AW'(x3_q);
				mul_b   = MUL_BW'(C0235);
				state_d = S_T_DEN;
			end
			S_T_DEN:   state_d = S_DEC_GO;
			S_DEC_GO: begin
				div_start = 1'b1;
				div_num   = (DIV_NW'(1) << 32) + DIV_NW'(den_q >> 1);
				div_den   = den_q;
				state_d   = S_DEC_WAIT;
			end
			S_DEC_WAIT: begin
				if (div_st.done) state_d = S_OC_GO;
			end
			S_OC_GO: begin
				div_start = 1'b1;
				div_num   = (DIV_NW'(change_mag) << 17) + DIV_NW'(half_st);
				div_den   = DIV_DW'(st_w);
				state_d   = S_OC_WAIT;
			end
			S_OC_WAIT: begin
				if (div_st.done) state_d = S_M_TMP;
			end
			S_M_TMP: begin
				mul_a   = MUL_AW'(vel_q) + MUL_AW'(oc_q);
				mul_b   = MUL_BW'(dt_q);
				state_d = S_T_TMP;
			end
			S_T_TMP:   state_d = S_OT_GO;
			S_OT_GO: begin
				div_start = 1'b1;
				div_num   = (DIV_NW'(temp_mag) << 17) + DIV_NW'(half_st);
				div_den   = DIV_DW'(st_w);
				state_d   = S_OT_WAIT;
			end
			S_OT_WAIT: begin
				if (div_st.done) state_d = S_M_NV;
			end
			S_M_NV: begin
				mul_a   = MUL_AW'(vel_q) - MUL_AW'(ot_q);
				mul_b   = MUL_BW'(dec_q);
				state_d = S_T_NV;
			end
			S_T_NV:    state_d = S_M_RES;
			S_M_RES: begin
				mul_a   = MUL_AW'(change_q) + MUL_AW'(temp_q);
				mul_b   = MUL_BW'(dec_q);
				state_d = S_T_RES;
			end
			S_T_RES: begin
				state_d = wrap_result_q ? S_WRR_GO : S_OUT;
			end
			S_WRR_GO: begin
				mul_a   = MUL_AW'(WRAP_RECIP);
				mul_b   = MUL_BW'(u_res_mag);
				state_d = S_WRR_Q;
			end
			S_WRR_Q:   state_d = S_WRR_M;
			S_WRR_M: begin
				mul_a   = MUL_AW'(wq_q);
				mul_b   = MUL_BW'(TWO_PI_Q12);
				state_d = S_WRR_FOLD;
			end
			S_WRR_FOLD: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || result.ready) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// configuration, stored velocity and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_time_q <= 16'd3745;
			wrap_result_q <= 1'b0;
			vel_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SMOOTH_TIME: smooth_time_q <= cfg_wdata;
					CFG_WRAP_RESULT: wrap_result_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (accept && sample.clear_velocity) begin
				vel_q <= '0;
			end else if (state_q == S_T_RES) begin
				if (snap_w) begin
					vel_q <= '0;
				end else if (nv_q > 41'(VEL_MAX)) begin
					vel_q <= 24'(VEL_MAX);
				end else if (nv_q < 41'(VEL_MIN)) begin
					vel_q <= 24'(VEL_MIN);
				end else begin
					vel_q <= nv_q[23:0];
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (accept) begin
			cur_q <= sample.current_angle;
			tgt_q <= sample.target_angle;
			dt_q  <= sample.time_step;
		end
		case (state_q)
			S_WRD_GO: begin
				neg_q  <= u_diff[17];
				wmag_q <= 28'(u_diff_mag);
			end
			S_WRD_Q:  wq_q <= prod_q[WRAP_SHIFT+WRAP_QW-1:WRAP_SHIFT];
			S_WRD_FOLD: begin
				diff_q <= wrap_fix(neg_q, wrap_rem);
				to_q   <= 18'(cur_q) + 18'(wrap_fix(neg_q, wrap_rem));
			end
			S_X_GO: begin
				// clamp the change to the limit set by smooth time
				if (chg_raw > maxc_s) begin
					change_q <= 17'(maxc_s);
				end else if (chg_raw < -maxc_s) begin
					change_q <= 17'(-maxc_s);
				end else begin
					change_q <= 17'(chg_raw);
				end
			end
			S_X_WAIT: begin
				if (div_st.done) begin
					x_q <= (div_quot > DIV_NW'(X_CAP)) ? 24'(X_CAP) : div_quot[23:0];
				end
			end
			S_T_X2:   x2_q  <= prod_r[30:0];
			S_T_X3:   x3_q  <= prod_r[37:0];
			S_T_C048: den_q <= DIV_DW'(65536) + DIV_DW'(x_q) + prod_r[DIV_DW-1:0];
			S_T_DEN:  den_q <= den_q + prod_r[DIV_DW-1:0];
			S_DEC_WAIT: begin
				if (div_st.done) dec_q <= div_quot[16:0];
			end
			S_OC_GO:  neg_q <= change_q[16];
			S_OC_WAIT: begin
				if (div_st.done) oc_q <= neg_q ? -q_oc : q_oc;
			end
			S_T_TMP:  temp_q <= prod_r[24:0];
			S_OT_GO:  neg_q  <= temp_q[24];
			S_OT_WAIT: begin
				if (div_st.done) ot_q <= neg_q ? -q_ot : q_ot;
			end
			S_T_NV:   nv_q <= prod_r[40:0];
			S_T_RES: begin
				res_q  <= snap_w ? 27'(to_q) : res_w;
				snap_q <= snap_w;
			end
			S_WRR_GO: begin
				neg_q  <= u_res[27];
				wmag_q <= u_res_mag;
			end
			S_WRR_Q:    wq_q  <= prod_q[WRAP_SHIFT+WRAP_QW-1:WRAP_SHIFT];
			S_WRR_FOLD: res_q <= 27'(wrap_fix(neg_q, wrap_rem));
			default: ;
		endcase
		if (load_out) begin
			out_angle_q <= res_sat;
			out_snap_q  <= snap_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.new_angle = out_angle_q;
	assign result.snapped   = out_snap_q;

	`CDAF_ASSERT_NEXT(a_snap_zero_vel, clk, arst_n, (state_q == S_T_RES) && snap_w, vel_q == '0)
	`CDAF_ASSERT_SAME(a_start_idle_div, clk, arst_n, div_start, !div_st.busy)
	`CDAF_ASSERT_SAME(a_ready_div_idle, clk, arst_n, sample.ready, !div_st.busy)
	`CDAF_ASSERT_SAME(a_out_from_seq, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_OUT)

endmodule
`default_nettype wire
